// ===== rtl/rhsm_pkg.sv =====
// Shared types, constants and helper functions for the rolling-hash string matcher.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rhsm_pkg;

	// Pattern and text geometry.
	localparam int PATTERN_MAX = 8;
	localparam int BYTE_W      = 8;
	localparam int HASH_W      = 32;
	localparam int CNT_W       = 32;
	localparam int LEN_W       = 4;
	localparam int PAT_W       = PATTERN_MAX * BYTE_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int CELL_IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [HASH_W-1:0]     hash_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [PAT_W-1:0]      pat_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_PATTERN_BYTES  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_PATTERN_LENGTH = cfg_idx_t'(1);

	// Reset values of the configuration registers.
	localparam pat_t PATTERN_BYTES_RST  = '0;
	localparam len_t PATTERN_LENGTH_RST = len_t'(1);

	// Status handed from the hash unit to the top level for one text byte.
	typedef struct packed {
		logic hash_eq;
		logic seen_ok;
		cnt_t start;
	} hash_status_t;

	// One result transaction.
	typedef struct packed {
		logic match_found;
		cnt_t match_start;
	} result_t;

	// Clamp the configured length into 1..PATTERN_MAX.
	function automatic len_t eff_len(input len_t raw);
		len_t l;
		l = raw;
		if (l < len_t'(1)) begin
			l = len_t'(1);
		end
		if (l > len_t'(PATTERN_MAX)) begin
			l = len_t'(PATTERN_MAX);
		end
		return l;
	endfunction

	// Shift-and-add hash of the first len pattern bytes, first byte weighted highest.
	function automatic hash_t pattern_hash(input pat_t pat, input len_t len);
		hash_t h;
		hash_t term;
		h = '0;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (len_t'(k) < len) begin
				term = hash_t'(pat[BYTE_W*k +: BYTE_W]);
				h = h + (term << (len - len_t'(k) - len_t'(1)));
			end
		end
		return h;
	endfunction

endpackage

// ===== rtl/rhsm_ifs.sv =====
// Valid/ready channel interfaces of the rolling-hash string matcher.
// Depends on rhsm_pkg for the payload types.
`timescale 1ns / 1ps

// Text byte channel.
interface rhsm_text_if;
	import rhsm_pkg::*;
	logic  valid;
	logic  ready;
	byte_t text_byte;
	logic  first_of_text;

	modport source (output valid, output text_byte, output first_of_text, input ready);
	modport sink   (input valid, input text_byte, input first_of_text, output ready);
endinterface

// Match result channel.
interface rhsm_result_if;
	import rhsm_pkg::*;
	logic valid;
	logic ready;
	logic match_found;
	cnt_t match_start;

	modport source (output valid, output match_found, output match_start, input ready);
	modport sink   (input valid, input match_found, input match_start, output ready);
endinterface

// Configuration write channel.
interface rhsm_cfg_if;
	import rhsm_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rhsm_cell.sv =====
// One window cell: holds a single text byte and compares its incoming byte to a pattern byte.
// Depends on rhsm_pkg.
`timescale 1ns / 1ps

module rhsm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rhsm_pkg::byte_t din,
	input  rhsm_pkg::byte_t pat_byte,
	input  logic          active,
	output rhsm_pkg::byte_t byte_q,
	output logic          hit
);
	import rhsm_pkg::*;

	// The cell takes its neighbor's byte on every accepted text transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (load) begin
			byte_q <= din;
		end
	end

	// Compare against the byte the cell is about to hold; cells beyond the pattern always agree.
	assign hit = !active || (din == pat_byte);

endmodule

// ===== rtl/rhsm_hash.sv =====
// Rolling hash and offset counter of the matcher, with the hash compare for the new window.
// Depends on rhsm_pkg.
`timescale 1ns / 1ps

module rhsm_hash (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic                     first,
	input  rhsm_pkg::byte_t          text_byte,
	input  rhsm_pkg::byte_t          oldest,
	input  rhsm_pkg::len_t           len,
	input  rhsm_pkg::hash_t          pat_hash,
	output rhsm_pkg::hash_status_t   status
);
	import rhsm_pkg::*;

	hash_t hash_q;
	cnt_t  seen_q;
	hash_t hash_base;
	cnt_t  seen_base;
	hash_t removed;
	hash_t hash_next;
	cnt_t  seen_next;

	// A new text starts from a cleared hash and count.
	assign hash_base = first ? '0 : hash_q;
	assign seen_base = first ? '0 : seen_q;

	// Drop the oldest byte's term, double, add the new byte.
	assign removed   = hash_t'(oldest) << (len - len_t'(1));
	assign hash_next = ((hash_base - removed) << 1) + hash_t'(text_byte);

	// The byte count saturates at its all-ones value.
	assign seen_next = (seen_base == '1) ? seen_base : seen_base + cnt_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			seen_q <= '0;
		end else if (load) begin
			hash_q <= hash_next;
			seen_q <= seen_next;
		end
	end

	// Status of the window that ends at the incoming byte.
	assign status.hash_eq = (hash_next == pat_hash);
	assign status.seen_ok = (seen_next >= cnt_t'(len));
	assign status.start   = seen_next - cnt_t'(len);

endmodule

// ===== rtl/rhsm_out_fifo.sv =====
// Two-entry result buffer that decouples the text side from a stalling result receiver.
// Depends on rhsm_pkg.
`timescale 1ns / 1ps

module rhsm_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rhsm_pkg::result_t push_data,
	output logic              not_full,
	output logic              not_empty,
	input  logic              pop,
	output rhsm_pkg::result_t head
);
	import rhsm_pkg::*;

	result_t     slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	// Payload slots carry no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign not_full  = (count_q != 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

endmodule

// ===== rtl/rolling_hash_string_matcher.sv =====
// Top level of the rolling-hash string matcher: cell chain, hash unit, result buffer.
// Depends on rhsm_pkg, rhsm_ifs, rhsm_cell, rhsm_hash and rhsm_out_fifo.
`timescale 1ns / 1ps

// Usage:
// Text bytes arrive on text_in, one per transaction; first_of_text set on a
// transaction clears the window, the hash and the offset before that byte is
// taken as offset 0. Every text transaction yields exactly one transaction on
// result_out: match_found and the start offset of the matching window (zero
// when there is no match). The pattern (up to eight bytes, first byte in the
// low byte) and its length are written through cfg while no text is in flight;
// cfg is always ready.
// result_out.valid is high in the cycle after a byte is taken.
// Throughput is one byte per cycle while text_in.ready is high, set by the window
// shift, hash roll and compare done on each accepted byte through the chain of byte cells.
// A two-entry result buffer lets one more byte be taken while a result waits;
// when both entries are held, text_in.ready drops until the receiver takes one.
// Reset clears the window, hash, offset and buffer, and sets the pattern to
// all zero with length one.
module rolling_hash_string_matcher (
	input  logic  clk,
	input  logic  arst_n,
	rhsm_text_if.sink     text_in,
	rhsm_result_if.source result_out,
	rhsm_cfg_if.sink      cfg
);
	import rhsm_pkg::*;

	pat_t   pattern_bytes_q;
	len_t   pattern_length_q;
	len_t   len;
	hash_t  pat_hash;
	logic   accept;
	logic   first;
	byte_t  oldest;
	byte_t  cell_din [PATTERN_MAX];
	byte_t  cell_byte [PATTERN_MAX];
	byte_t  cell_pat [PATTERN_MAX];
	logic   [PATTERN_MAX-1:0] cell_active;
	logic   [PATTERN_MAX-1:0] cell_hit;
	hash_status_t status;
	result_t res;
	result_t head;
	logic   fifo_not_full;
	logic   fifo_not_empty;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q  <= PATTERN_BYTES_RST;
			pattern_length_q <= PATTERN_LENGTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PATTERN_BYTES:  pattern_bytes_q  <= cfg.data[PAT_W-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len      = eff_len(pattern_length_q);
	assign pat_hash = pattern_hash(pattern_bytes_q, len);

	// Text handshake.
	assign text_in.ready = fifo_not_full;
	assign accept        = text_in.valid && fifo_not_full;
	assign first         = text_in.first_of_text;

	// Chain of window cells; cell 0 holds the newest byte.
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [LEN_W-1:0] pidx;
		if (k == 0) begin : g_head
			assign cell_din[k] = text_in.text_byte;
		end else begin : g_link
			assign cell_din[k] = first ? byte_t'(0) : cell_byte[k-1];
		end
		// Cell k lines up with pattern byte len-1-k.
		assign pidx           = len - len_t'(1) - len_t'(k);
		assign cell_active[k] = len_t'(k) < len;
		assign cell_pat[k]    = pattern_bytes_q[BYTE_W*pidx[CELL_IDX_W-1:0] +: BYTE_W];

		rhsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (accept),
			.din      (cell_din[k]),
			.pat_byte (cell_pat[k]),
			.active   (cell_active[k]),
			.byte_q   (cell_byte[k]),
			.hit      (cell_hit[k])
		);
	end

	// Byte leaving the window; a new text removes a cleared zero.
	assign oldest = first ? byte_t'(0) : cell_byte[CELL_IDX_W'(len - len_t'(1))];

	rhsm_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.first     (first),
		.text_byte (text_in.text_byte),
		.oldest    (oldest),
		.len       (len),
		.pat_hash  (pat_hash),
		.status    (status)
	);

	// Match decision for the window ending at the incoming byte.
	assign res.match_found = status.hash_eq && status.seen_ok && (&cell_hit);
	assign res.match_start = res.match_found ? status.start : '0;

	rhsm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.not_full  (fifo_not_full),
		.not_empty (fifo_not_empty),
		.pop       (result_out.valid && result_out.ready),
		.head      (head)
	);

	assign result_out.valid       = fifo_not_empty;
	assign result_out.match_found = head.match_found;
	assign result_out.match_start = head.match_start;

`ifndef ASSERT_OFF
	// Every taken byte leaves a result ready on the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_out.valid)
		else $error("no result offered after a text transaction");

	// A fresh text cannot match a pattern longer than one byte on its first byte.
	a_no_early_match: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && first && len > len_t'(1)) |-> !res.match_found)
		else $error("match reported before the window filled");

	// A non-match carries a zero offset.
	a_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !res.match_found) |-> (res.match_start == '0))
		else $error("offset set without a match");

	// Configured length is always clamped into range.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len >= len_t'(1)) && (len <= len_t'(PATTERN_MAX)))
		else $error("effective pattern length out of range");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the rolling-hash string matcher.
// Depends on rhsm_pkg, the channel interfaces in rhsm_ifs and the top level of the block.
`timescale 1ns / 1ps

module testbench;
	import rhsm_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_BYTES = 1400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rhsm_text_if   text_ch ();
	rhsm_result_if res_ch ();
	rhsm_cfg_if    cfg_ch ();

	rolling_hash_string_matcher DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_ch),
		.result_out (res_ch),
		.cfg        (cfg_ch)
	);

	// Free-running clock, 20 ns period.
	always #10 clk = ~clk;

	// Mirror of the matcher: window, rolling hash, offset and pattern registers.
	byte_t win [PATTERN_MAX];
	hash_t win_hash;
	cnt_t  seen;
	pat_t  pat_reg;
	len_t  len_reg;

	result_t match_queue [$];

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  results_checked = 0;
	int  matches_seen = 0;
	int  reg_writes = 0;
	int  quiet_cycles = 0;
	int  stall_left = 0;
	bit  idle_on = 1'b1;

	// Pattern length as the block uses it: zero counts as one, above the maximum is clamped.
	function automatic int active_len();
		int l;
		l = int'(len_reg);
		if (l < 1) begin
			l = 1;
		end
		if (l > PATTERN_MAX) begin
			l = PATTERN_MAX;
		end
		return l;
	endfunction

	// Shift-and-add sum over the first n pattern bytes, first byte weighted highest.
	function automatic hash_t pattern_sum(input int n);
		hash_t h;
		h = '0;
		for (int k = 0; k < n; k++) begin
			h = (h << 1) + hash_t'(pat_reg[BYTE_W*k +: BYTE_W]);
		end
		return h;
	endfunction

	// Take one text byte into the mirrored window and work out the match verdict.
	function automatic result_t roll_and_compare(input byte_t b, input logic first);
		result_t r;
		int      n;
		logic    same;
		r = '0;
		n = active_len();
		if (first) begin
			foreach (win[i]) begin
				win[i] = '0;
			end
			win_hash = '0;
			seen = '0;
		end
		win_hash = win_hash - (hash_t'(win[n-1]) << (n - 1));
		win_hash = (win_hash << 1) + hash_t'(b);
		for (int k = PATTERN_MAX - 1; k > 0; k--) begin
			win[k] = win[k-1];
		end
		win[0] = b;
		if (seen != '1) begin
			seen = seen + cnt_t'(1);
		end
		// The hash only gates the byte compare; the bytes decide the match.
		if (seen >= cnt_t'(n) && win_hash == pattern_sum(n)) begin
			same = 1'b1;
			for (int k = 0; k < n; k++) begin
				if (win[n-1-k] != pat_reg[BYTE_W*k +: BYTE_W]) begin
					same = 1'b0;
				end
			end
			if (same) begin
				r.match_found = 1'b1;
				r.match_start = seen - cnt_t'(n);
			end
		end
		return r;
	endfunction

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int sender_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Extra stall cycles on the result side: mostly short, now and then a long one.
	function automatic int stall_length();
		if ($urandom_range(0, 99) < 90) begin
			return $urandom_range(0, 2);
		end
		return $urandom_range(10, 40);
	endfunction

	// Present one text byte and wait for its transaction; predict its result on acceptance.
	task automatic send_byte(input byte_t b, input logic first);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid         <= 1'b1;
		text_ch.text_byte     <= b;
		text_ch.first_of_text <= first;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		match_queue.push_back(roll_and_compare(b, first));
		bytes_sent++;
	endtask

	// Stop sending and wait until every expected result has been taken.
	task automatic settle_block();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (match_queue.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// One configuration write transaction; valid is dropped after it.
	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_PATTERN_BYTES) begin
			pat_reg = pat_t'(value);
		end else if (idx == REG_PATTERN_LENGTH) begin
			len_reg = len_t'(value[LEN_W-1:0]);
		end
		reg_writes++;
		@(posedge clk);
	endtask

	// Result side: random stalls on ready, and each result transaction checked in order.
	always @(posedge clk) begin
		result_t want;
		if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			res_ch.ready <= 1'b0;
			stall_left <= stall_length();
		end else begin
			res_ch.ready <= 1'b1;
		end

		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (match_queue.size() == 0) begin
				$display("%0t: result with none expected, match_found %0b match_start %0d",
					$time, res_ch.match_found, res_ch.match_start);
				mismatches++;
			end else begin
				want = match_queue.pop_front();
				results_checked++;
				if (res_ch.match_found !== want.match_found) begin
					$display("%0t: match_found expected %0b, actual %0b",
						$time, want.match_found, res_ch.match_found);
					mismatches++;
				end
				if (res_ch.match_start !== want.match_start) begin
					$display("%0t: match_start expected %0d, actual %0d",
						$time, want.match_start, res_ch.match_start);
					mismatches++;
				end
				if (want.match_found) begin
					matches_seen++;
				end
			end
		end
	end

	// Count cycles in which no transaction completes on any channel.
	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("rolling_hash_string_matcher verification failed");
		$finish;
	end

	// Text that starts without a first-of-text flag, under the reset pattern (one NUL byte).
	task automatic test_reset_state();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// Length zero behaves as one; lengths above the maximum behave as the maximum.
	task automatic test_length_extremes();
		settle_block();
		write_reg(REG_PATTERN_BYTES, cfg_data_t'(64'hFF));
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(0));
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		settle_block();
		write_reg(REG_PATTERN_BYTES, '1);
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(15));
		for (int i = 0; i < 9; i++) begin
			send_byte(8'hFF, i == 0);
		end
	endtask

	// A window whose hash equals the pattern hash but whose bytes differ must not match.
	task automatic test_hash_collision();
		settle_block();
		write_reg(REG_PATTERN_BYTES, cfg_data_t'(64'h4241));
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(2));
		send_byte(8'h40, 1'b1);
		send_byte(8'h44, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
	endtask

	// Length changed inside a text: the hash is not rebuilt until the next new text.
	task automatic test_length_change_midtext();
		settle_block();
		write_reg(REG_PATTERN_BYTES, cfg_data_t'(64'h434241));
		send_byte(8'h41, 1'b1);
		send_byte(8'h42, 1'b0);
		settle_block();
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(3));
		send_byte(8'h43, 1'b0);
		settle_block();
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(1));
		send_byte(8'h41, 1'b0);
		settle_block();
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(3));
		send_byte(8'h41, 1'b1);
		send_byte(8'h42, 1'b0);
		send_byte(8'h43, 1'b0);
	endtask

	// Pick a new pattern and length for a phase of random texts.
	task automatic pick_setting();
		pat_t p;
		int   sel;
		int   len_pick;
		byte_t alphabet [4];
		alphabet = '{8'h00, 8'h01, 8'h41, 8'hFF};
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			p = '0;
		end else if (sel == 1) begin
			p = '1;
		end else if (sel < 6) begin
			p = {$urandom, $urandom};
		end else begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				p[BYTE_W*k +: BYTE_W] = alphabet[$urandom_range(0, 3)];
			end
		end
		if ($urandom_range(0, 4) == 0) begin
			len_pick = $urandom_range(0, 15);
		end else begin
			len_pick = $urandom_range(1, 8);
		end
		write_reg(REG_PATTERN_BYTES, cfg_data_t'(p));
		write_reg(REG_PATTERN_LENGTH, cfg_data_t'(len_pick));
	endtask

	// Build one text: pattern copies, near-copies and partial copies among filler bytes.
	task automatic build_text(ref byte_t text_buf [$]);
		int    n;
		int    pieces;
		int    r;
		int    j;
		int    cut;
		byte_t piece [PATTERN_MAX];
		n = active_len();
		text_buf.delete();
		pieces = $urandom_range(1, 8);
		for (int p = 0; p < pieces; p++) begin
			r = $urandom_range(0, 99);
			for (int k = 0; k < n; k++) begin
				piece[k] = pat_reg[BYTE_W*k +: BYTE_W];
			end
			if (r < 40) begin
				// Exact copy of the pattern.
				for (int k = 0; k < n; k++) begin
					text_buf.push_back(piece[k]);
				end
			end else if (r < 55 && n > 1) begin
				// Near-copy that keeps the hash of the pattern.
				j = $urandom_range(0, n - 2);
				piece[j] = piece[j] + 8'd1;
				piece[j+1] = piece[j+1] - 8'd2;
				for (int k = 0; k < n; k++) begin
					text_buf.push_back(piece[k]);
				end
			end else if (r < 65) begin
				// Truncated copy.
				cut = $urandom_range(0, n - 1);
				for (int k = 0; k < cut; k++) begin
					text_buf.push_back(piece[k]);
				end
			end else begin
				// Filler, half drawn from the pattern bytes.
				cut = $urandom_range(1, 6);
				for (int k = 0; k < cut; k++) begin
					if ($urandom_range(0, 1) == 0) begin
						text_buf.push_back(pat_reg[BYTE_W*$urandom_range(0, n - 1) +: BYTE_W]);
					end else begin
						text_buf.push_back(byte_t'($urandom_range(0, 255)));
					end
				end
			end
		end
		if (text_buf.size() == 0) begin
			text_buf.push_back(byte_t'($urandom_range(0, 255)));
		end
	endtask

	// Phases of random texts under random settings and idling.
	task automatic test_random_texts();
		byte_t text_buf [$];
		int    stop_at;
		int    phase_end;
		logic  lead_first;
		stop_at = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < stop_at) begin
			settle_block();
			idle_on = ($urandom_range(0, 3) != 0);
			pick_setting();
			phase_end = bytes_sent + $urandom_range(60, 140);
			// Some phases carry the previous text on across the new setting.
			lead_first = ($urandom_range(0, 99) >= 15);
			while (bytes_sent < phase_end) begin
				build_text(text_buf);
				foreach (text_buf[i]) begin
					if (i == 0) begin
						send_byte(text_buf[i], lead_first);
					end else begin
						send_byte(text_buf[i], $urandom_range(0, 99) < 2);
					end
				end
				lead_first = ($urandom_range(0, 99) >= 5);
			end
		end
		idle_on = 1'b1;
	endtask

	// Reset, then the tests in turn, then the verdict.
	initial begin
		foreach (win[i]) begin
			win[i] = '0;
		end
		win_hash = '0;
		seen     = '0;
		pat_reg  = PATTERN_BYTES_RST;
		len_reg  = PATTERN_LENGTH_RST;
		text_ch.valid         <= 1'b0;
		text_ch.text_byte     <= '0;
		text_ch.first_of_text <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= '0;
		cfg_ch.data           <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_length_extremes();
		test_hash_collision();
		test_length_change_midtext();
		test_random_texts();

		settle_block();
		repeat (4) @(posedge clk);
		if (match_queue.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, match_queue.size());
		end
		$display("Covered %0d text bytes with %0d results checked and %0d matches found,",
			bytes_sent, results_checked, matches_seen);
		$display("under %0d register writes; %0d mismatches.", reg_writes, mismatches);
		if (mismatches == 0 && match_queue.size() == 0) begin
			$display("rolling_hash_string_matcher verification clean");
		end else begin
			$display("rolling_hash_string_matcher verification failed");
		end
		$finish;
	end

endmodule
